[sv/rst_pkg.sv]
// ----------------------------------------------------------------------------
// Reservation station table package
// Shared types, operation and status codes, sizing constants.
// ----------------------------------------------------------------------------
package rst_pkg;

    localparam int DEPTH_DEF       = 8;
    localparam int ROB_ENTRIES_DEF = 32;
    localparam int MAX_RESULTS     = 8;
    localparam int QUEUE_DEPTH     = 2;

    typedef enum logic [2:0] {
        OP_INSERT    = 3'd0,
        OP_BROADCAST = 3'd1,
        OP_SELECT    = 3'd2,
        OP_REMOVE    = 3'd3,
        OP_FLUSH     = 3'd4,
        OP_SET_BUSY  = 3'd5
    } op_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_FULL      = 2'd1,
        ST_NOT_FOUND = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_SCAN,
        BK_SHIFT
    } back_state_t;

    typedef struct packed {
        logic [2:0]         operation;
        logic [4:0]         dest_tag;
        logic               is_store;
        logic               busy_flag;
        logic signed [31:0] value_j;
        logic signed [31:0] value_k;
        logic               wait_j;
        logic [4:0]         tag_j;
        logic               wait_k;
        logic [4:0]         tag_k;
        logic [31:0]        cycle;
        logic [7:0]         exec_cycles;
    } req_t;

    typedef struct packed {
        logic [1:0]         status;
        logic               found;
        logic [4:0]         out_dest_tag;
        logic signed [31:0] out_value_j;
        logic signed [31:0] out_value_k;
        logic               out_is_store;
        logic [3:0]         occupancy;
        logic               last;
    } rsp_t;

endpackage

[sv/rst_queue.sv]
// ----------------------------------------------------------------------------
// Request queue
// Small FIFO that decouples the accepting front from the table engine.
// ----------------------------------------------------------------------------
module rst_queue (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          in_valid,
    output logic          in_ready,
    input  rst_pkg::req_t in_req,
    output logic          out_valid,
    input  logic          out_ready,
    output rst_pkg::req_t out_req
);
    localparam int N = rst_pkg::QUEUE_DEPTH;

    rst_pkg::req_t mem_reg [N];
    logic [$clog2(N)-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [$clog2(N):0]   count_reg;
    logic push, pop;

    assign in_ready  = (count_reg != N[$clog2(N):0]);
    assign out_valid = (count_reg != '0);
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;
    assign out_req   = mem_reg[rd_ptr_reg];

    // storage
    always_ff @(posedge aclk) begin
        if (push) mem_reg[wr_ptr_reg] <= in_req;
    end

    // pointers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop)  rd_ptr_reg <= rd_ptr_reg + 1'b1;
            count_reg <= count_reg + {{$clog2(N){1'b0}}, push}
                                   - {{$clog2(N){1'b0}}, pop};
        end
    end
endmodule

[sv/rst_engine.sv]
// ----------------------------------------------------------------------------
// Table engine
// Holds the station table and carries out one request at a time.
// ----------------------------------------------------------------------------
module rst_engine #(
    parameter int DEPTH = rst_pkg::DEPTH_DEF
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          cfg_valid,
    output logic          cfg_ready,
    input  logic [3:0]    cfg_data,
    input  logic          req_valid,
    output logic          req_ready,
    input  rst_pkg::req_t req,
    output logic          m_valid,
    input  logic          m_ready,
    output rst_pkg::rsp_t m_data
);
    localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    typedef struct packed {
        logic [4:0]  dest;
        logic        store;
        logic        wait_j;
        logic [4:0]  tag_j;
        logic [31:0] val_j;
        logic        wait_k;
        logic [4:0]  tag_k;
        logic [31:0] val_k;
        logic [31:0] issue;
        logic [7:0]  remaining;
    } slot_t;

    slot_t               slot_reg [DEPTH];
    logic [DEPTH-1:0]    busy_reg;
    logic [CW-1:0]       used_reg;
    logic [3:0]          cap_reg;
    rst_pkg::back_state_t state_reg, state_next;
    logic [31:0]         cyc_reg;
    logic [IW-1:0]       idx_reg, idx_next;
    logic [3:0]          nres_reg, nres_next;
    logic                out_valid_reg, out_valid_next;
    rst_pkg::rsp_t       out_reg, out_next;

    logic out_free;
    logic [DEPTH-1:0] valid_v, ready_v, match_v;
    logic [IW-1:0] first_idx;
    logic          any_match;
    logic          rest_ready;
    logic [CW-1:0] eff_cap;

    assign cfg_ready = 1'b1;
    assign out_free  = !out_valid_reg || m_ready;
    assign req_ready = (state_reg == rst_pkg::BK_IDLE) && out_free;
    assign m_valid   = out_valid_reg;
    assign m_data    = out_reg;
    assign eff_cap   = ({{(CW > 4 ? CW-4 : 0){1'b0}}, cap_reg} > CW'(DEPTH)) ?
                       CW'(DEPTH) : CW'(cap_reg);

    // per-entry ready and tag match flags; ready uses the select's cycle
    always_comb begin
        for (int i = 0; i < DEPTH; i++) begin
            valid_v[i] = CW'(i) < used_reg;
            ready_v[i] = valid_v[i] && busy_reg[i]
                && (slot_reg[i].issue < cyc_reg) && (slot_reg[i].remaining != 0)
                && !slot_reg[i].wait_j && (!slot_reg[i].wait_k || slot_reg[i].store);
            match_v[i] = valid_v[i] && (slot_reg[i].dest == req.dest_tag);
        end
    end

    // oldest matching entry
    always_comb begin
        first_idx = '0;
        any_match = 1'b0;
        for (int i = DEPTH - 1; i >= 0; i--) begin
            if (match_v[i]) begin
                first_idx = IW'(i);
                any_match = 1'b1;
            end
        end
    end

    // any ready entry younger than the scan position
    always_comb begin
        rest_ready = 1'b0;
        for (int i = 0; i < DEPTH; i++)
            if (IW'(i) > idx_reg && ready_v[i]) rest_ready = 1'b1;
    end

    function automatic rst_pkg::rsp_t plain(input rst_pkg::status_t st,
                                            input logic [CW-1:0] occ);
        rst_pkg::rsp_t r;
        r = '0;
        r.status    = st;
        r.occupancy = 4'(occ);
        r.last      = 1'b1;
        return r;
    endfunction

    // sequencer: select walks the table one slot a cycle while the result is free, remove shifts
    always_comb begin
        state_next     = state_reg;
        idx_next       = idx_reg;
        nres_next      = nres_reg;
        out_valid_next = out_valid_reg && !m_ready;
        out_next       = out_reg;
        unique case (state_reg)
            rst_pkg::BK_IDLE: begin
                if (req_valid && req_ready) begin
                    out_valid_next = 1'b1;
                    out_next       = plain(rst_pkg::ST_OK, used_reg);
                    case (req.operation)
                        rst_pkg::OP_INSERT: begin
                            if (used_reg >= eff_cap)
                                out_next = plain(rst_pkg::ST_FULL, used_reg);
                            else
                                out_next = plain(rst_pkg::ST_OK, used_reg + 1'b1);
                        end
                        rst_pkg::OP_SELECT: begin
                            out_valid_next = 1'b0;
                            state_next     = rst_pkg::BK_SCAN;
                            idx_next       = '0;
                            nres_next      = '0;
                        end
                        rst_pkg::OP_REMOVE: begin
                            if (any_match) begin
                                out_valid_next = 1'b0;
                                state_next     = rst_pkg::BK_SHIFT;
                                idx_next       = first_idx;
                            end else begin
                                out_next = plain(rst_pkg::ST_NOT_FOUND, used_reg);
                            end
                        end
                        rst_pkg::OP_FLUSH: begin
                            if (any_match)
                                out_next = plain(rst_pkg::ST_OK, CW'(first_idx) + 1'b1);
                            else
                                out_next = plain(rst_pkg::ST_NOT_FOUND, used_reg);
                        end
                        rst_pkg::OP_SET_BUSY: begin
                            if (!any_match)
                                out_next = plain(rst_pkg::ST_NOT_FOUND, used_reg);
                        end
                        default: ;
                    endcase
                end
            end
            rst_pkg::BK_SCAN: begin
                if (out_free) begin
                    idx_next = idx_reg + 1'b1;
                    if (ready_v[idx_reg]) begin
                        out_valid_next        = 1'b1;
                        out_next              = '0;
                        out_next.status       = rst_pkg::ST_OK;
                        out_next.found        = 1'b1;
                        out_next.out_dest_tag = slot_reg[idx_reg].dest;
                        out_next.out_value_j  = slot_reg[idx_reg].val_j;
                        out_next.out_value_k  = slot_reg[idx_reg].val_k;
                        out_next.out_is_store = slot_reg[idx_reg].store;
                        out_next.occupancy    = 4'(used_reg);
                        nres_next             = nres_reg + 4'd1;
                        // last when nothing younger is ready or the list is full
                        if (!rest_ready || nres_reg == 4'(rst_pkg::MAX_RESULTS - 1)) begin
                            out_next.last = 1'b1;
                            state_next    = rst_pkg::BK_IDLE;
                        end
                    end else if (!rest_ready) begin
                        // nothing ready at all
                        out_valid_next = 1'b1;
                        out_next       = plain(rst_pkg::ST_OK, used_reg);
                        state_next     = rst_pkg::BK_IDLE;
                    end
                end
            end
            rst_pkg::BK_SHIFT: begin
                idx_next = idx_reg + 1'b1;
                if (CW'(idx_reg) + 2'd2 >= used_reg) begin
                    state_next     = rst_pkg::BK_IDLE;
                    out_valid_next = 1'b1;
                    out_next       = plain(rst_pkg::ST_OK, used_reg - 1'b1);
                end
            end
            default: state_next = rst_pkg::BK_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= rst_pkg::BK_IDLE;
            used_reg      <= '0;
            busy_reg      <= '0;
            cap_reg       <= 4'd8;
            out_valid_reg <= 1'b0;
            idx_reg       <= '0;
            nres_reg      <= '0;
        end else begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            nres_reg      <= nres_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid) cap_reg <= cfg_data;
            unique case (state_reg)
                rst_pkg::BK_IDLE: begin
                    if (req_valid && req_ready) begin
                        case (req.operation)
                            rst_pkg::OP_INSERT: begin
                                if (!(used_reg >= eff_cap)) begin
                                    busy_reg[IW'(used_reg)] <= req.busy_flag;
                                    used_reg <= used_reg + 1'b1;
                                end
                            end
                            rst_pkg::OP_FLUSH: begin
                                if (any_match) begin
                                    for (int i = 0; i < DEPTH; i++)
                                        if (IW'(i) > first_idx) busy_reg[i] <= 1'b0;
                                    used_reg <= CW'(first_idx) + 1'b1;
                                end
                            end
                            rst_pkg::OP_SET_BUSY: begin
                                if (any_match) busy_reg[first_idx] <= req.busy_flag;
                            end
                            default: ;
                        endcase
                    end
                end
                rst_pkg::BK_SHIFT: begin
                    if (CW'(idx_reg) + 1'b1 < used_reg)
                        busy_reg[idx_reg] <= busy_reg[idx_reg + 1'b1];
                    if (state_next == rst_pkg::BK_IDLE) begin
                        used_reg <= used_reg - 1'b1;
                        busy_reg[IW'(used_reg - 1'b1)] <= 1'b0;
                    end
                end
                default: ;
            endcase
        end
    end

    // payload registers: slot fields, select cycle, result
    always_ff @(posedge aclk) begin
        out_reg <= out_next;
        unique case (state_reg)
            rst_pkg::BK_IDLE: begin
                if (req_valid && req_ready) begin
                    cyc_reg <= req.cycle;
                    case (req.operation)
                        rst_pkg::OP_INSERT: begin
                            if (!(used_reg >= eff_cap))
                                slot_reg[IW'(used_reg)] <= '{req.dest_tag, req.is_store,
                                    req.wait_j, req.tag_j, req.value_j, req.wait_k,
                                    req.tag_k, req.value_k, req.cycle, req.exec_cycles};
                        end
                        rst_pkg::OP_BROADCAST: begin
                            for (int i = 0; i < DEPTH; i++) begin
                                if (valid_v[i] && busy_reg[i]) begin
                                    if (slot_reg[i].wait_j && slot_reg[i].tag_j == req.tag_j) begin
                                        slot_reg[i].val_j  <= req.value_j;
                                        slot_reg[i].wait_j <= 1'b0;
                                    end
                                    if (slot_reg[i].wait_k && slot_reg[i].tag_k == req.tag_j) begin
                                        slot_reg[i].val_k  <= req.value_j;
                                        slot_reg[i].wait_k <= 1'b0;
                                    end
                                end
                            end
                        end
                        default: ;
                    endcase
                end
            end
            rst_pkg::BK_SHIFT: begin
                if (CW'(idx_reg) + 1'b1 < used_reg)
                    slot_reg[idx_reg] <= slot_reg[idx_reg + 1'b1];
            end
            default: ;
        endcase
    end
endmodule

[sv/reservation_station_table_core.sv]
// ----------------------------------------------------------------------------
// Reservation station table core
// Tomasulo station table in insertion order, front queue plus table engine.
// ----------------------------------------------------------------------------
// Channel | Prefix | Payload
// input   | s_     | rst_pkg::req_t request
// result  | m_     | rst_pkg::rsp_t result, last marks final of request
// config  | cfg_   | 4-bit capacity
//
// Most requests pass through the queue, then the engine's registered result.
// Select walks one slot a cycle while the result is not stalled.
// Remove shifts one slot a cycle to compact the table.
// Synchronous active-low reset empties the table; capacity resets to 8.
// A stalled result holds the engine; the queue keeps accepting until it is full.
// ----------------------------------------------------------------------------
module reservation_station_table_core #(
    parameter int DEPTH = rst_pkg::DEPTH_DEF
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          cfg_valid,
    output logic          cfg_ready,
    input  logic [3:0]    cfg_data,
    input  logic          s_valid,
    output logic          s_ready,
    input  rst_pkg::req_t s_data,
    output logic          m_valid,
    input  logic          m_ready,
    output rst_pkg::rsp_t m_data
);
    logic          q_valid, q_ready;
    rst_pkg::req_t q_req;

    rst_queue u_queue (
        .aclk, .aresetn,
        .in_valid(s_valid), .in_ready(s_ready), .in_req(s_data),
        .out_valid(q_valid), .out_ready(q_ready), .out_req(q_req)
    );

    rst_engine #(.DEPTH(DEPTH)) u_engine (
        .aclk, .aresetn,
        .cfg_valid, .cfg_ready, .cfg_data,
        .req_valid(q_valid), .req_ready(q_ready), .req(q_req),
        .m_valid, .m_ready, .m_data
    );
endmodule

[sv/rst_checker.sv]
// ----------------------------------------------------------------------------
// Port checker
// Watches the top-level ports of the station table core.
// ----------------------------------------------------------------------------
module rst_checker (
    input logic          aclk,
    input logic          aresetn,
    input logic          m_valid,
    input logic          m_ready,
    input rst_pkg::rsp_t m_data
);
    // a held result keeps its payload
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> $stable(m_data))
        else $error("result changed while stalled");

    // occupancy never exceeds eight
    a_occ: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_data.occupancy <= 4'd8)
        else $error("occupancy out of range");

    // found results report ok
    a_found: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.found |-> m_data.status == rst_pkg::ST_OK)
        else $error("found with bad status");

    // non-select results are final
    a_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_data.found |-> m_data.last)
        else $error("plain result without last");
endmodule

bind reservation_station_table_core rst_checker u_rst_checker (.*);
